FILE: rtl/lgrs_pkg.sv
// Shared types and constants for the linear gain ramp with saturation.
package lgrs_pkg;

    localparam int GAIN_FRAC_BITS = 24;
    localparam int LENGTH_BITS    = 20;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int PCT_W    = 23;
    localparam int LEN_W    = 21;
    localparam int ACC_W    = 48;
    localparam int CFG_W    = PCT_W;

    // percent difference and divider widths
    localparam int DIFF_W   = PCT_W + 1;
    localparam int NUM_W    = DIFF_W + GAIN_FRAC_BITS;
    localparam int EL_W     = LENGTH_BITS + 1;
    localparam int DEN_W    = EL_W + 7;
    localparam int DIV_CNT_W = $clog2(NUM_W + 1);
    localparam int CMP_W    = (LEN_W > EL_W) ? LEN_W : EL_W;

    localparam logic [DEN_W-1:0] PCT_DEN = DEN_W'(100);
    localparam logic [CMP_W-1:0] LEN_CAP = CMP_W'(1) << LENGTH_BITS;

    // datapath widths: sample magnitude, clipped gain magnitude, products
    localparam int MS_W  = SAMPLE_W + 1;
    localparam int MG_W  = GAIN_FRAC_BITS + 17;
    localparam int HI_W  = MG_W - GAIN_FRAC_BITS;
    localparam int LO_PW = MS_W + GAIN_FRAC_BITS;
    localparam int HI_PW = MS_W + HI_W;
    localparam int Q_W   = HI_PW + 1;

    // any gain magnitude at or above this saturates every nonzero sample
    localparam logic [ACC_W-1:0] GAIN_CLIP = ACC_W'(1) << (GAIN_FRAC_BITS + 16);

    // gain for the reset register values (100 percent)
    localparam logic [ACC_W-1:0] START_GAIN_RST =
        ACC_W'((64'd100 << GAIN_FRAC_BITS) / 64'd100);

    localparam logic [Q_W-1:0] SAT_POS_WIDE   = Q_W'(32767);
    localparam logic [Q_W-1:0] SAT_NEG_WIDE   = Q_W'(32768);
    localparam logic [Q_W-1:0] SAT_POS_NARROW = Q_W'(127);
    localparam logic [Q_W-1:0] SAT_NEG_NARROW = Q_W'(128);

    localparam logic [PCT_W-1:0] PCT_RST = PCT_W'(100);
    localparam logic [LEN_W-1:0] LEN_RST = LEN_W'(1);

    typedef enum logic [1:0] {
        CFG_START_PCT = 2'd0,
        CFG_END_PCT   = 2'd1,
        CFG_RAMP_LEN  = 2'd2,
        CFG_WIDE      = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        SEQ_RUN,
        SEQ_GAIN_GO,
        SEQ_GAIN_WAIT,
        SEQ_STEP_GO,
        SEQ_STEP_WAIT
    } t_seq;

endpackage

FILE: rtl/lgrs_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module lgrs_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lgrs_pkg::NUM_W-1:0]  i_num,
    input  logic [lgrs_pkg::DEN_W-1:0]  i_den,
    output logic                        o_done,
    output logic [lgrs_pkg::NUM_W-1:0]  o_quo
);
    import lgrs_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0]     r_q;
    logic [DEN_W-1:0]     r_rem;
    logic [DEN_W-1:0]     r_den;

    logic [DEN_W:0]       rem_sh;
    logic [DEN_W:0]       rem_sub;
    logic                 ge;

    always_comb begin
        rem_sh  = {r_rem, r_q[NUM_W-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        ge      = (rem_sh >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[NUM_W-2:0], ge};
            r_rem <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

FILE: rtl/linear_gain_ramp_saturate_core.sv
// Top level: linear gain ramp over sample runs with truncation and saturation.
//
// Input words (i_sample_value) enter on i_valid/o_ready; results leave on
// o_valid/i_ready as o_scaled_sample with o_run_end marking the last word
// of a ramp run. One word per cycle is sustained while the receiver keeps
// up and no configuration reload runs; each word is registered after the
// gain and sample magnitudes, partial-product multiply, and sum and saturate.
// The pipeline has per-stage valid bits, so a word is still taken while a
// finished result waits: the stages fill up behind a stalled receiver and
// o_ready drops when all three are full or while a configuration reload runs.
// Configuration: i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data.
// Each write reloads the start gain and per-word step through a shared
// serial divider (two quotients, one after the other), so o_ready and
// o_cfg_ready stay low after a write until both quotients are done.
// Reset loads the default registers (100 %, 100 %, length 1, 8-bit words)
// and their gain directly; the block is ready as soon as reset is released.
module linear_gain_ramp_saturate_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [lgrs_pkg::SAMPLE_W-1:0] i_sample_value,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [lgrs_pkg::SAMPLE_W-1:0] o_scaled_sample,
    output logic                               o_run_end,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  lgrs_pkg::t_cfg_idx                 i_cfg_index,
    input  logic [lgrs_pkg::CFG_W-1:0]         i_cfg_data
);
    import lgrs_pkg::*;

    // configuration
    logic signed [PCT_W-1:0] r_start;
    logic signed [PCT_W-1:0] r_end;
    logic [LEN_W-1:0]        r_len;
    logic                    r_wide;

    // ramp state
    t_seq                    r_seq, n_seq;
    logic [LENGTH_BITS-1:0]  r_pos;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] r_step;
    logic signed [ACC_W-1:0] r_start_gain;

    // pipeline
    logic                    r_s1_valid, r_s2_valid, r_out_valid;
    logic [MS_W-1:0]         r_s1_ms;
    logic [MG_W-1:0]         r_s1_mg;
    logic                    r_s1_neg, r_s1_end, r_s1_wide;
    logic [LO_PW-1:0]        r_s2_lo;
    logic [HI_PW-1:0]        r_s2_hi;
    logic                    r_s2_neg, r_s2_end, r_s2_wide;
    logic [SAMPLE_W-1:0]     r_out_sample;
    logic                    r_out_end, r_out_wide;

    // sequencer outputs
    logic                    div_start;
    logic                    div_sel_step;
    logic                    seq_run;

    logic                    div_done;
    logic [NUM_W-1:0]        div_quo;
    logic [NUM_W-1:0]        div_num;
    logic [DEN_W-1:0]        div_den;

    logic                    cfg_acc, in_acc;
    logic                    en1, en2, en_out;

    // ---------------- length and divider operands ----------------
    logic [CMP_W-1:0]         len_x, eff_x;
    logic [EL_W-1:0]          eff_len;
    logic [LENGTH_BITS-1:0]   last;
    logic signed [DIFF_W-1:0] start_x, diff_x;
    logic [DIFF_W-1:0]        start_mag, diff_mag;
    logic [ACC_W-1:0]         quo_x, quo_neg;

    always_comb begin
        len_x = CMP_W'(r_len);
        if (len_x == '0) begin
            eff_x = CMP_W'(1);
        end else if (len_x > LEN_CAP) begin
            eff_x = LEN_CAP;
        end else begin
            eff_x = len_x;
        end
        eff_len = EL_W'(eff_x);
        last    = LENGTH_BITS'(eff_len - EL_W'(1));

        start_x   = DIFF_W'(r_start);
        diff_x    = DIFF_W'(r_end) - DIFF_W'(r_start);
        start_mag = start_x[DIFF_W-1] ? DIFF_W'(-start_x) : DIFF_W'(start_x);
        diff_mag  = diff_x[DIFF_W-1] ? DIFF_W'(-diff_x) : DIFF_W'(diff_x);

        if (div_sel_step) begin
            div_num = {diff_mag, GAIN_FRAC_BITS'(0)};
            div_den = DEN_W'(DEN_W'(eff_len) * PCT_DEN);
        end else begin
            div_num = {start_mag, GAIN_FRAC_BITS'(0)};
            div_den = PCT_DEN;
        end

        quo_x   = ACC_W'(div_quo);
        quo_neg = ACC_W'(0) - quo_x;
    end

    lgrs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // ---------------- sequencer ----------------
    always_comb begin
        n_seq = r_seq;
        unique case (r_seq)
            SEQ_RUN:       if (cfg_acc) n_seq = SEQ_GAIN_GO;
            SEQ_GAIN_GO:   n_seq = SEQ_GAIN_WAIT;
            SEQ_GAIN_WAIT: if (div_done) n_seq = SEQ_STEP_GO;
            SEQ_STEP_GO:   n_seq = SEQ_STEP_WAIT;
            SEQ_STEP_WAIT: if (div_done) n_seq = SEQ_RUN;
            default:       n_seq = SEQ_RUN;
        endcase
    end

    always_comb begin
        div_start    = 1'b0;
        div_sel_step = 1'b0;
        seq_run      = 1'b0;
        unique case (r_seq)
            SEQ_RUN:       seq_run = 1'b1;
            SEQ_GAIN_GO:   div_start = 1'b1;
            SEQ_GAIN_WAIT: div_sel_step = 1'b0;
            SEQ_STEP_GO: begin
                div_start    = 1'b1;
                div_sel_step = 1'b1;
            end
            SEQ_STEP_WAIT: div_sel_step = 1'b1;
            default:       seq_run = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= SEQ_RUN;
        end else begin
            r_seq <= n_seq;
        end
    end

    // ---------------- handshakes ----------------
    assign en_out      = !r_out_valid || i_ready;
    assign en2         = !r_s2_valid || en_out;
    assign en1         = !r_s1_valid || en2;
    assign o_ready     = seq_run && en1;
    assign o_cfg_ready = seq_run;
    assign in_acc      = i_valid && o_ready;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    // ---------------- configuration registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= PCT_RST;
            r_end   <= PCT_RST;
            r_len   <= LEN_RST;
            r_wide  <= 1'b0;
        end else if (cfg_acc) begin
            unique case (i_cfg_index)
                CFG_START_PCT: r_start <= i_cfg_data;
                CFG_END_PCT:   r_end   <= i_cfg_data;
                CFG_RAMP_LEN:  r_len   <= i_cfg_data[LEN_W-1:0];
                CFG_WIDE:      r_wide  <= i_cfg_data[0];
                default:       r_wide  <= r_wide;
            endcase
        end
    end

    // ---------------- ramp state ----------------
    logic run_last;
    assign run_last = (r_pos >= last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_acc        <= START_GAIN_RST;
            r_step       <= '0;
            r_start_gain <= START_GAIN_RST;
        end else if (r_seq == SEQ_GAIN_WAIT && div_done) begin
            r_start_gain <= start_x[DIFF_W-1] ? quo_neg : quo_x;
        end else if (r_seq == SEQ_STEP_WAIT && div_done) begin
            r_step <= diff_x[DIFF_W-1] ? quo_neg : quo_x;
            r_acc  <= r_start_gain;
            r_pos  <= '0;
        end else if (in_acc) begin
            if (run_last) begin
                r_pos <= '0;
                r_acc <= r_start_gain;
            end else begin
                r_pos <= r_pos + LENGTH_BITS'(1);
                r_acc <= r_acc + r_step;
            end
        end
    end

    // ---------------- stage 1: magnitudes and signs ----------------
    logic signed [SAMPLE_W-1:0] s_ext;
    logic signed [MS_W-1:0]     s_x;
    logic [MS_W-1:0]            s_mag;
    logic [ACC_W-1:0]           g_mag;
    logic [MG_W-1:0]            g_clip;

    always_comb begin
        s_ext  = r_wide ? i_sample_value : SAMPLE_W'(i_sample_value[7:0]) ;
        if (!r_wide) begin
            s_ext = {{(SAMPLE_W-8){i_sample_value[7]}}, i_sample_value[7:0]};
        end
        s_x    = MS_W'(s_ext);
        s_mag  = s_x[MS_W-1] ? MS_W'(-s_x) : MS_W'(s_x);
        g_mag  = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
        g_clip = (g_mag >= GAIN_CLIP) ? MG_W'(GAIN_CLIP) : MG_W'(g_mag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en1) begin
            r_s1_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && in_acc) begin
            r_s1_ms   <= s_mag;
            r_s1_mg   <= g_clip;
            r_s1_neg  <= s_x[MS_W-1] ^ r_acc[ACC_W-1];
            r_s1_end  <= run_last;
            r_s1_wide <= r_wide;
        end
    end

    // ---------------- stage 2: partial products ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r_s1_valid) begin
            r_s2_lo   <= LO_PW'(r_s1_ms) * LO_PW'(r_s1_mg[GAIN_FRAC_BITS-1:0]);
            r_s2_hi   <= HI_PW'(r_s1_ms) * HI_PW'(r_s1_mg[MG_W-1:GAIN_FRAC_BITS]);
            r_s2_neg  <= r_s1_neg;
            r_s2_end  <= r_s1_end;
            r_s2_wide <= r_s1_wide;
        end
    end

    // ---------------- stage 3: sum, saturate, sign ----------------
    logic [Q_W-1:0] q_sum, q_lim, q_sat, q_out;

    always_comb begin
        q_sum = Q_W'(r_s2_hi) + Q_W'(r_s2_lo >> GAIN_FRAC_BITS);
        if (r_s2_neg) begin
            q_lim = r_s2_wide ? SAT_NEG_WIDE : SAT_NEG_NARROW;
        end else begin
            q_lim = r_s2_wide ? SAT_POS_WIDE : SAT_POS_NARROW;
        end
        q_sat = (q_sum > q_lim) ? q_lim : q_sum;
        q_out = r_s2_neg ? (Q_W'(0) - q_sat) : q_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out && r_s2_valid) begin
            r_out_sample <= q_out[SAMPLE_W-1:0];
            r_out_end    <= r_s2_end;
            r_out_wide   <= r_s2_wide;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_scaled_sample = $signed(r_out_sample);
    assign o_run_end       = r_out_end;

    // ---------------- assertions ----------------
    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_seq == SEQ_GAIN_WAIT || r_seq == SEQ_STEP_WAIT))
        else $error("divider finished outside a wait state");

    a_pos_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == SEQ_RUN) |-> (r_pos <= last))
        else $error("run position beyond last word");

    a_cfg_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> (!o_ready && !o_cfg_ready))
        else $error("block ready while gain reload pending");

    a_narrow_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_wide) |->
            (r_out_sample[SAMPLE_W-1:7] == '0 || r_out_sample[SAMPLE_W-1:7] == '1))
        else $error("narrow result outside 8-bit range");

endmodule

FILE: tb/sv/lgrs_fade_checker.sv
`timescale 1ns / 1ps
// Checker for the gain ramp core: predicts each faded word and compares it with the output.
module lgrs_fade_checker
    import lgrs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [SAMPLE_W-1:0] i_in_sample,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [SAMPLE_W-1:0] i_out_sample,
    input  logic                i_out_run_end,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  t_cfg_idx            i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data,
    output int                  o_errors,
    output int                  o_pending,
    output int                  o_checked,
    output int                  o_run_ends
);

    localparam int MAX_PRINTS = 30;

    typedef struct packed {
        logic [SAMPLE_W-1:0] scaled;
        logic                run_end;
    } faded_t;

    faded_t expected_words[$];

    logic signed [PCT_W-1:0]  start_pct;
    logic signed [PCT_W-1:0]  end_pct;
    logic [LEN_W-1:0]         len_reg;
    logic                     wide_mode;
    logic [LENGTH_BITS-1:0]   fade_pos;
    logic signed [ACC_W-1:0]  fade_gain;
    logic signed [ACC_W-1:0]  fade_step;

    int errors   = 0;
    int checked  = 0;
    int run_ends = 0;

    // zero acts as one, anything above the counter range is capped
    function automatic longint ramp_span(input logic [LEN_W-1:0] n);
        longint span;
        span = longint'(n);
        if (span == 0)
            span = 1;
        if (span > (64'sd1 <<< LENGTH_BITS))
            span = 64'sd1 <<< LENGTH_BITS;
        return span;
    endfunction

    function automatic longint fade_start_gain();
        return (longint'(start_pct) * (64'sd1 <<< GAIN_FRAC_BITS)) / 64'sd100;
    endfunction

    function automatic void restart_fade();
        longint den;
        longint diff;
        den       = 100 * ramp_span(len_reg);
        diff      = longint'(end_pct) - longint'(start_pct);
        fade_step = ACC_W'((diff * (64'sd1 <<< GAIN_FRAC_BITS)) / den);
        fade_gain = ACC_W'(fade_start_gain());
        fade_pos  = '0;
    endfunction

    // one word through the gain: truncate toward zero, saturate, advance the ramp
    function automatic faded_t fade_word(input logic [SAMPLE_W-1:0] raw);
        longint      s;
        longint      g;
        logic [63:0] ms;
        logic [63:0] mg;
        logic [63:0] q;
        logic [63:0] lim;
        logic        neg;
        faded_t      r;
        s   = wide_mode ? longint'($signed(raw)) : longint'($signed(raw[7:0]));
        g   = longint'(fade_gain);
        neg = (s < 0) != (g < 0);
        ms  = (s < 0) ? -s : s;
        mg  = (g < 0) ? -g : g;
        q   = (ms * mg) >> GAIN_FRAC_BITS;
        if (ms == 0 || mg == 0)
            neg = 1'b0;
        if (neg)
            lim = wide_mode ? 64'd32768 : 64'd128;
        else
            lim = wide_mode ? 64'd32767 : 64'd127;
        if (q > lim)
            q = lim;
        r.scaled  = neg ? SAMPLE_W'(-q) : SAMPLE_W'(q);
        r.run_end = longint'(fade_pos) >= ramp_span(len_reg) - 1;
        if (r.run_end) begin
            fade_pos  = '0;
            fade_gain = ACC_W'(fade_start_gain());
        end else begin
            fade_pos  = fade_pos + 1'b1;
            fade_gain = fade_gain + fade_step;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] got,
                                   input logic [SAMPLE_W-1:0] want);
        if (errors < MAX_PRINTS)
            $display("%0t ns: word %0d: %s got %h want %h", $time, checked, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin : monitor
        faded_t want;
        if (!i_rst_n) begin
            start_pct = PCT_RST;
            end_pct   = PCT_RST;
            len_reg   = LEN_RST;
            wide_mode = 1'b0;
            restart_fade();
            expected_words.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word", i_out_sample, '0);
                end else begin
                    want = expected_words.pop_front();
                    if (i_out_sample !== want.scaled)
                        report_mismatch("scaled sample", i_out_sample, want.scaled);
                    if (i_out_run_end !== want.run_end)
                        report_mismatch("run end", SAMPLE_W'(i_out_run_end),
                                        SAMPLE_W'(want.run_end));
                    checked++;
                    if (want.run_end)
                        run_ends++;
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_START_PCT: start_pct = i_cfg_data;
                    CFG_END_PCT:   end_pct   = i_cfg_data;
                    CFG_RAMP_LEN:  len_reg   = i_cfg_data[LEN_W-1:0];
                    CFG_WIDE:      wide_mode = i_cfg_data[0];
                    default: ;
                endcase
                restart_fade();
            end
            if (i_in_valid && i_in_ready)
                expected_words.push_back(fade_word(i_in_sample));
        end
        o_errors   <= errors;
        o_pending  <= expected_words.size();
        o_checked  <= checked;
        o_run_ends <= run_ends;
    end

endmodule

FILE: tb/sv/linear_gain_ramp_saturate_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for the gain ramp core: reset, stimulus, flow control and verdict.
module linear_gain_ramp_saturate_core_tb;
    import lgrs_pkg::*;

    localparam int     PHASES          = 8;
    localparam int     WORDS_PER_PHASE = 190;
    localparam int     HOLD_CYCLES     = 300;
    localparam int     DRAIN_LIMIT     = 20000;
    localparam int     TAIL_CYCLES     = 8;
    localparam longint LIMIT_NS        = 2000000;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_ready;
    logic signed [SAMPLE_W-1:0] i_sample_value;
    logic                       o_valid;
    logic                       i_ready;
    logic signed [SAMPLE_W-1:0] o_scaled_sample;
    logic                       o_run_end;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    t_cfg_idx                   i_cfg_index;
    logic [CFG_W-1:0]           i_cfg_data;

    int   errors;
    int   pending;
    int   checked;
    int   run_ends;
    int   send_idle_pct;
    int   recv_stall_pct;
    logic hold_req;
    int   words_sent = 0;
    int   settings   = 0;

    always #4 i_clk = ~i_clk;

    linear_gain_ramp_saturate_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_sample_value  (i_sample_value),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_scaled_sample (o_scaled_sample),
        .o_run_end       (o_run_end),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    lgrs_fade_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_in_sample   (i_sample_value),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_out_sample  (o_scaled_sample),
        .i_out_run_end (o_run_end),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_run_ends    (run_ends)
    );

    // returns at the edge that takes the word; valid stays up for a back-to-back word
    task automatic push_word(input logic [SAMPLE_W-1:0] v);
        int gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_sample_value <= v;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        words_sent++;
    endtask

    task automatic wait_drained();
        int waited = 0;
        i_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_setting(input logic [CFG_W-1:0] start_pct,
                                input logic [CFG_W-1:0] end_pct,
                                input logic [CFG_W-1:0] len, input logic wide);
        wait_drained();
        write_reg(CFG_START_PCT, start_pct);
        write_reg(CFG_END_PCT, end_pct);
        write_reg(CFG_RAMP_LEN, len);
        write_reg(CFG_WIDE, {$urandom_range(1) ? 22'h3FFFFF : 22'h0, wide});
        settings++;
    endtask

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER: begin
                send_idle_pct  <= 74;
                recv_stall_pct <= 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct  <= 0;
                recv_stall_pct <= 74;
            end
            IDLE_BOTH: begin
                send_idle_pct  <= 12;
                recv_stall_pct <= 12;
            end
            default: begin
                send_idle_pct  <= 0;
                recv_stall_pct <= 0;
            end
        endcase
    endtask

    function automatic logic [CFG_W-1:0] pick_percent();
        case ($urandom_range(9))
            6: return CFG_W'(-200);
            7: return CFG_W'(3276700);
            8: return CFG_W'($urandom);
            9: return $urandom_range(1) ? {1'b0, {(CFG_W-1){1'b1}}} : {1'b1, {(CFG_W-1){1'b0}}};
            default: return CFG_W'(int'($urandom_range(600)) - 200);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_length();
        case ($urandom_range(9))
            7: return '0;
            8: return CFG_W'($urandom_range(5000, 41));
            9: return CFG_W'($urandom);
            default: return CFG_W'($urandom_range(40, 1));
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            7: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
            8: return SAMPLE_W'($urandom_range(6)) - 16'd3;
            9: return $urandom_range(1) ? 16'h007F : 16'hFF80;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    initial begin : receiver
        int n;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++)
                    @(posedge i_clk);
                hold_req <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin : stimulus
        int ph;
        int k;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_sample_value <= '0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= CFG_START_PCT;
        i_cfg_data     <= '0;
        send_idle_pct  <= 0;
        recv_stall_pct <= 0;
        hold_req       <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: unity gain, run of one, narrow words (upper byte ignored)
        push_word(16'h007F);
        push_word(16'hFF80);
        push_word(16'h0000);
        push_word(16'h7FFF);
        push_word(16'h8000);
        push_word(16'h0080);

        // equal percentages at 2x, length zero, wide words: saturation both ways
        load_setting(CFG_W'(200), CFG_W'(200), '0, 1'b1);
        push_word(16'h7FFF);
        push_word(16'h8000);
        push_word(16'h3FFF);
        push_word(16'hC000);
        push_word(16'h0001);

        // ramp from negative gain upward in narrow mode
        load_setting(CFG_W'(-200), CFG_W'(3276700), CFG_W'(3), 1'b0);
        push_word(16'h0064);
        push_word(16'hFF9C);
        push_word(16'h007F);
        push_word(16'h5580);

        // extreme percentages, length above the cap
        load_setting({1'b0, {(CFG_W-1){1'b1}}}, {1'b1, {(CFG_W-1){1'b0}}},
                     CFG_W'(21'h1FFFFF), 1'b1);
        push_word(16'h0001);
        push_word(16'hFFFF);
        push_word(16'h7FFF);
        push_word(16'h0000);

        // zero start gain, length just over the cap
        load_setting('0, CFG_W'(100), CFG_W'(21'h100001), 1'b0);
        push_word(16'h007F);
        push_word(16'hFF80);

        for (ph = 0; ph < PHASES; ph++) begin
            load_setting(pick_percent(), pick_percent(), pick_length(),
                         1'($urandom_range(1)));
            set_idle(idle_mode_t'(ph % 4));
            for (k = 0; k < WORDS_PER_PHASE; k++) begin
                // stall the output long enough for the pipeline to back up
                if (ph == 0 && k == 20)
                    hold_req <= 1'b1;
                push_word(pick_sample());
            end
        end
        wait_drained();

        $display("covered %0d words over %0d register settings: %0d checked, %0d run ends",
                 words_sent, settings, checked, run_ends);
        $display("flow control: free running, sender idle, receiver stall, both, long hold-off");
        if (pending != 0)
            $display("%0d expected words never came out", pending);
        if (errors == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/lgrs_pkg.sv
rtl/lgrs_div.sv
rtl/linear_gain_ramp_saturate_core.sv
tb/sv/lgrs_fade_checker.sv
tb/sv/linear_gain_ramp_saturate_core_tb.sv
